>>> rtl/mrx_pkg.sv
`timescale 1ns / 1ps

package mrx_pkg;

  localparam int unsigned XLEN = 64;
  localparam int unsigned WLEN = 32;

  // SPECIAL-class funct codes
  localparam logic [5:0] FN_SLL    = 6'd0;
  localparam logic [5:0] FN_SRL    = 6'd2;
  localparam logic [5:0] FN_SRA    = 6'd3;
  localparam logic [5:0] FN_SLLV   = 6'd4;
  localparam logic [5:0] FN_SRLV   = 6'd6;
  localparam logic [5:0] FN_JR     = 6'd8;
  localparam logic [5:0] FN_JALR   = 6'd9;
  localparam logic [5:0] FN_SYNC   = 6'd15;
  localparam logic [5:0] FN_MFLO   = 6'd18;
  localparam logic [5:0] FN_DSLLV  = 6'd20;
  localparam logic [5:0] FN_MULTU  = 6'd25;
  localparam logic [5:0] FN_ADD    = 6'd32;
  localparam logic [5:0] FN_ADDU   = 6'd33;
  localparam logic [5:0] FN_SUBU   = 6'd35;
  localparam logic [5:0] FN_AND    = 6'd36;
  localparam logic [5:0] FN_OR     = 6'd37;
  localparam logic [5:0] FN_XOR    = 6'd38;
  localparam logic [5:0] FN_NOR    = 6'd39;
  localparam logic [5:0] FN_SLT    = 6'd42;
  localparam logic [5:0] FN_SLTU   = 6'd43;
  localparam logic [5:0] FN_DSLL   = 6'd56;
  localparam logic [5:0] FN_DSLL32 = 6'd60;
  localparam logic [5:0] FN_DSRA32 = 6'd63;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_UNKNOWN  = 2'd2
  } status_t;

  typedef struct packed {
    logic [5:0]      command;
    logic [XLEN-1:0] rs_value;
    logic [XLEN-1:0] rt_value;
    logic [4:0]      dest_index;
    logic [4:0]      shift_amount;
    logic [XLEN-1:0] next_pc;
  } req_t;

  typedef struct packed {
    status_t         status;
    logic            write_enable;
    logic [4:0]      write_index;
    logic [XLEN-1:0] write_value;
    logic            jump_taken;
    logic [XLEN-1:0] jump_target;
  } rsp_t;

  function automatic logic [XLEN-1:0] sext32(input logic [WLEN-1:0] v);
    return {{(XLEN-WLEN){v[WLEN-1]}}, v};
  endfunction

endpackage

>>> rtl/mrx_req_if.sv
`timescale 1ns / 1ps

interface mrx_req_if;
  logic        valid;
  logic        ready;
  logic [5:0]  command;
  logic [63:0] rs_value;
  logic [63:0] rt_value;
  logic [4:0]  dest_index;
  logic [4:0]  shift_amount;
  logic [63:0] next_pc;

  modport source (
    output valid, command, rs_value, rt_value, dest_index, shift_amount, next_pc,
    input  ready
  );
  modport sink (
    input  valid, command, rs_value, rt_value, dest_index, shift_amount, next_pc,
    output ready
  );
endinterface

>>> rtl/mrx_rsp_if.sv
`timescale 1ns / 1ps

interface mrx_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        write_enable;
  logic [4:0]  write_index;
  logic [63:0] write_value;
  logic        jump_taken;
  logic [63:0] jump_target;

  modport source (
    output valid, status, write_enable, write_index, write_value, jump_taken, jump_target,
    input  ready
  );
  modport sink (
    input  valid, status, write_enable, write_index, write_value, jump_taken, jump_target,
    output ready
  );
endinterface

>>> rtl/mips64_rtype_execute_top.sv
`timescale 1ns / 1ps

// Execute stage for 64-bit MIPS SPECIAL-class instructions.
// Channels: req carries one decoded instruction (funct, rs/rt values, rd,
// shift amount, next PC); rsp returns one result per instruction (status,
// register write, jump). Both are valid/ready; a transaction completes on a
// rising edge with valid and ready high.
// A transaction accepted on req is held in the input register, evaluated
// combinationally from it and shown on rsp once the result register takes it.
// Throughput: one instruction per cycle while rsp does not stall. The input
// register and the result register are the only stages; the 32x32 multu
// product is the longest path and lands directly in the HI/LO words, so an
// mflo right behind a multu reads the new LO.
// Reset (rst, synchronous): both stages empty, HI and LO cleared.
// Stall: while rsp.ready is low the result is held; the input register
// still takes one more transaction if it is empty, then req.ready drops.
// Overflowing add reports status 1 with no write; unknown funct reports 2.
module mips64_rtype_execute_top (
  input  logic          clk,
  input  logic          rst,
  mrx_req_if.sink       req,
  mrx_rsp_if.source     rsp
);

  logic                          s1_valid;
  mrx_pkg::req_t                 s1;
  logic                          s1_advance;
  logic                          out_valid;
  mrx_pkg::rsp_t                 out;
  mrx_pkg::rsp_t                 out_next;
  logic [mrx_pkg::XLEN-1:0]      hi_word;
  logic [mrx_pkg::XLEN-1:0]      lo_word;
  logic [2*mrx_pkg::WLEN-1:0]    product;

  logic [mrx_pkg::WLEN-1:0]      rs32;
  logic [mrx_pkg::WLEN-1:0]      rt32;
  logic [4:0]                    var_shamt;
  logic [mrx_pkg::WLEN-1:0]      sum32;
  logic                          add_ovf;
  logic                          wr;
  logic                          jmp;
  logic [mrx_pkg::XLEN-1:0]      val;
  mrx_pkg::status_t              st;

  assign s1_advance = s1_valid && (!out_valid || rsp.ready);
  assign req.ready  = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1.command      <= req.command;
      s1.rs_value     <= req.rs_value;
      s1.rt_value     <= req.rt_value;
      s1.dest_index   <= req.dest_index;
      s1.shift_amount <= req.shift_amount;
      s1.next_pc      <= req.next_pc;
    end
  end

  assign rs32      = s1.rs_value[mrx_pkg::WLEN-1:0];
  assign rt32      = s1.rt_value[mrx_pkg::WLEN-1:0];
  assign var_shamt = s1.rs_value[4:0];
  assign sum32     = rs32 + rt32;
  assign add_ovf   = ~(rs32[31] ^ rt32[31]) & (rs32[31] ^ sum32[31]);
  assign product   = (2*mrx_pkg::WLEN)'(rs32) * (2*mrx_pkg::WLEN)'(rt32);

  always_comb begin
    st  = mrx_pkg::ST_OK;
    wr  = 1'b1;
    jmp = 1'b0;
    val = '0;
    unique case (s1.command)
      mrx_pkg::FN_SLL:    val = mrx_pkg::sext32(rt32 << s1.shift_amount);
      mrx_pkg::FN_SRL:    val = mrx_pkg::sext32(rt32 >> s1.shift_amount);
      mrx_pkg::FN_SRA:    val = mrx_pkg::sext32(
                                  32'($signed(s1.rt_value) >>> s1.shift_amount));
      mrx_pkg::FN_SLLV:   val = mrx_pkg::sext32(rt32 << var_shamt);
      mrx_pkg::FN_SRLV:   val = mrx_pkg::sext32(rt32 >> var_shamt);
      mrx_pkg::FN_JR: begin
        wr  = 1'b0;
        jmp = 1'b1;
      end
      mrx_pkg::FN_JALR: begin
        jmp = 1'b1;
        val = s1.next_pc;
      end
      mrx_pkg::FN_SYNC:   wr  = 1'b0;
      mrx_pkg::FN_MFLO:   val = lo_word;
      mrx_pkg::FN_DSLLV:  val = s1.rt_value << s1.rs_value[5:0];
      mrx_pkg::FN_MULTU:  wr  = 1'b0;
      mrx_pkg::FN_ADD: begin
        if (add_ovf) begin
          st = mrx_pkg::ST_OVERFLOW;
          wr = 1'b0;
        end else begin
          val = mrx_pkg::sext32(sum32);
        end
      end
      mrx_pkg::FN_ADDU:   val = mrx_pkg::sext32(sum32);
      mrx_pkg::FN_SUBU:   val = mrx_pkg::sext32(rs32 - rt32);
      mrx_pkg::FN_AND:    val = s1.rs_value & s1.rt_value;
      mrx_pkg::FN_OR:     val = s1.rs_value | s1.rt_value;
      mrx_pkg::FN_XOR:    val = s1.rs_value ^ s1.rt_value;
      mrx_pkg::FN_NOR:    val = ~(s1.rs_value | s1.rt_value);
      mrx_pkg::FN_SLT:    val = {63'd0, $signed(s1.rs_value) < $signed(s1.rt_value)};
      mrx_pkg::FN_SLTU:   val = {63'd0, s1.rs_value < s1.rt_value};
      mrx_pkg::FN_DSLL:   val = s1.rt_value << s1.shift_amount;
      mrx_pkg::FN_DSLL32: val = {rt32, 32'd0} << s1.shift_amount;
      mrx_pkg::FN_DSRA32: val = $signed(s1.rt_value) >>> {1'b1, s1.shift_amount};
      default: begin
        st = mrx_pkg::ST_UNKNOWN;
        wr = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_next.status       = st;
    out_next.write_enable = wr;
    out_next.write_index  = wr ? s1.dest_index : 5'd0;
    out_next.write_value  = wr ? val : '0;
    out_next.jump_taken   = jmp;
    out_next.jump_target  = jmp ? s1.rs_value : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out <= out_next;
    end
  end

  // update HI/LO as the multu leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hi_word <= '0;
      lo_word <= '0;
    end else if (s1_advance && s1.command == mrx_pkg::FN_MULTU) begin
      hi_word <= mrx_pkg::sext32(product[2*mrx_pkg::WLEN-1:mrx_pkg::WLEN]);
      lo_word <= mrx_pkg::sext32(product[mrx_pkg::WLEN-1:0]);
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out.status;
  assign rsp.write_enable = out.write_enable;
  assign rsp.write_index  = out.write_index;
  assign rsp.write_value  = out.write_value;
  assign rsp.jump_taken   = out.jump_taken;
  assign rsp.jump_target  = out.jump_target;

  a_err_no_side_effect: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != mrx_pkg::ST_OK |-> !rsp.write_enable && !rsp.jump_taken)
    else $error("error status with write or jump");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid && $stable(s1))
    else $error("input register lost a waiting transaction");

  a_hi_sext: assert property (@(posedge clk) disable iff (rst)
    (&hi_word[63:31]) || !(|hi_word[63:31]))
    else $error("HI not sign-extended");

  a_lo_sext: assert property (@(posedge clk) disable iff (rst)
    (&lo_word[63:31]) || !(|lo_word[63:31]))
    else $error("LO not sign-extended");

endmodule
